@@ hdl/rtr_pkg.sv @@
// Types and constants shared by the reliable transport receiver.
// No dependencies; the design files take names from here by scope, the verification files by import.
`default_nettype none

package rtr_pkg;

  typedef logic [31:0] seq_t;
  typedef logic [15:0] half_t;
  typedef logic [10:0] len_t;

  typedef enum logic [2:0] {
    PH_LISTEN      = 3'd0,
    PH_SYN_RCVD    = 3'd1,
    PH_ESTABLISHED = 3'd2,
    PH_LAST_ACK    = 3'd3,
    PH_CLOSED      = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_SYN_ACK    = 3'd0,
    KIND_ACK        = 3'd1,
    KIND_FIN_ACK    = 3'd2,
    KIND_FIN        = 3'd3,
    KIND_RESENT_ACK = 3'd4,
    KIND_CLOSED     = 3'd5
  } kind_e;

  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [1:0] CFG_INITIAL_SEQ = 2'd0;
  localparam logic [1:0] CFG_SEG_STEP    = 2'd1;
  localparam logic [1:0] CFG_RESEND      = 2'd2;

  localparam seq_t  INITIAL_SEQ_RST = 32'd0;
  localparam half_t SEG_STEP_RST    = 16'd1400;
  localparam half_t RESEND_RST      = 16'd100;
  localparam half_t TICK_MAX        = 16'hFFFF;

  // One queued answer; pair marks a second word to follow.
  typedef struct packed {
    kind_e kind;
    seq_t  seq;
    seq_t  ack;
    len_t  wlen;
    logic  pair;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/rtr_ifs.sv @@
// Channel interfaces of the reliable transport receiver: segment input,
// result output and configuration write. Depends on rtr_pkg.
`default_nettype none

interface rtr_seg_if;
  logic          valid;
  logic          ready;
  logic          opcode;
  rtr_pkg::seq_t seg_seq;
  rtr_pkg::seq_t seg_ack;
  logic          seg_syn;
  logic          seg_fin;
  rtr_pkg::len_t seg_length;
  modport source (output valid, opcode, seg_seq, seg_ack, seg_syn, seg_fin, seg_length,
                  input ready);
  modport sink (input valid, opcode, seg_seq, seg_ack, seg_syn, seg_fin, seg_length,
                output ready);
endinterface

interface rtr_res_if;
  logic          valid;
  logic          ready;
  logic [2:0]    kind;
  rtr_pkg::seq_t out_seq;
  rtr_pkg::seq_t out_ack;
  logic          out_syn;
  logic          out_fin;
  rtr_pkg::len_t write_length;
  logic          last;
  modport source (output valid, kind, out_seq, out_ack, out_syn, out_fin, write_length, last,
                  input ready);
  modport sink (input valid, kind, out_seq, out_ack, out_syn, out_fin, write_length, last,
                output ready);
endinterface

interface rtr_cfg_if;
  logic          valid;
  logic          ready;
  logic [1:0]    index;
  rtr_pkg::seq_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/reliable_transport_receiver.sv @@
// Receiver side of a TCP-like transport: handshake, in-order accept, ACKs.
// Top level; depends on rtr_pkg, rtr_ifs, rtr_front, rtr_fifo, rtr_back.
//
// seg_i carries one word per segment header or millisecond tick; res_o
// returns the answers (SYN-ACK, ACK, FIN-ACK, FIN, resent ACK, closed),
// with last set on the final word caused by an input. cfg_i writes the
// initial sequence number, the segment step and the resend interval; it is
// always ready. It must be written only while the block is idle, which the
// block itself does not enforce. Throughput: one input word per cycle while
// the queue has space. Connection state updates in the cycle a word is
// accepted; answers then wait in a QueueDepth-entry queue. Each answer
// passes through the queue and the result register before res_o shows it.
// A paired answer takes two result words, so the sustained input rate is
// set by the single result register, one word a cycle while res_o.ready.
// When the result sink stalls, the queue fills and seg_i.ready drops; ticks
// and silent segments also wait for queue space.
// Reset empties the queue, clears the output and returns to listen with
// the configuration at its reset values.
`default_nettype none

module reliable_transport_receiver #(
  parameter int QueueDepth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rtr_seg_if.sink   seg_i,
  rtr_cfg_if.sink   cfg_i,
  rtr_res_if.source res_o
);

  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  rtr_pkg::entry_t entry;
  rtr_pkg::entry_t head;

  rtr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .seg_i   (seg_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  rtr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  rtr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

@@ hdl/rtr_front.sv @@
// Front end: accepts segment and tick words, keeps connection state and
// configuration, and queues the answers. Depends on rtr_pkg and rtr_ifs.
`default_nettype none

module rtr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  rtr_seg_if.sink              seg_i,
  rtr_cfg_if.sink              cfg_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output rtr_pkg::entry_t      entry_o
);

  rtr_pkg::phase_e phase_q, phase_d;
  rtr_pkg::seq_t   exp_seq_q, exp_seq_d;
  rtr_pkg::seq_t   hs_ack_q, hs_ack_d;
  rtr_pkg::seq_t   close_seq_q, close_seq_d;
  rtr_pkg::half_t  ticks_q, ticks_d;
  rtr_pkg::seq_t   isn_q;
  rtr_pkg::half_t  step_q;
  rtr_pkg::half_t  resend_q;

  logic           fire;
  logic           is_tick;
  logic           hs_ok;
  logic           in_order;
  logic           resend;
  logic           fin_match;
  rtr_pkg::seq_t  seq_plus1;
  rtr_pkg::seq_t  ack_val;
  rtr_pkg::half_t ticks_eff;

  assign seg_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;

  assign fire      = seg_i.valid && seg_i.ready;
  assign is_tick   = seg_i.opcode == rtr_pkg::OP_TICK;
  assign seq_plus1 = seg_i.seg_seq + 32'd1;
  assign hs_ok     = !seg_i.seg_syn && (seg_i.seg_seq == hs_ack_q)
                     && (seg_i.seg_ack == isn_q + 32'd1);
  assign in_order  = seg_i.seg_seq == exp_seq_q;
  assign ack_val   = in_order ? seg_i.seg_seq + {16'd0, step_q} : exp_seq_q;
  assign ticks_eff = in_order ? '0 : ticks_q;
  assign resend    = ticks_eff >= resend_q;
  assign fin_match = seg_i.seg_ack == close_seq_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isn_q    <= rtr_pkg::INITIAL_SEQ_RST;
      step_q   <= rtr_pkg::SEG_STEP_RST;
      resend_q <= rtr_pkg::RESEND_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rtr_pkg::CFG_INITIAL_SEQ: isn_q    <= cfg_i.data;
        rtr_pkg::CFG_SEG_STEP:    step_q   <= cfg_i.data[15:0];
        rtr_pkg::CFG_RESEND:      resend_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    exp_seq_d   = exp_seq_q;
    hs_ack_d    = hs_ack_q;
    close_seq_d = close_seq_q;
    ticks_d     = ticks_q;
    if (fire) begin
      if (is_tick) begin
        if (ticks_q != rtr_pkg::TICK_MAX) ticks_d = ticks_q + 16'd1;
      end else begin
        case (phase_q)
          rtr_pkg::PH_LISTEN: begin
            if (seg_i.seg_syn) begin
              hs_ack_d = seq_plus1;
              phase_d  = rtr_pkg::PH_SYN_RCVD;
            end
          end
          rtr_pkg::PH_SYN_RCVD: begin
            if (hs_ok) begin
              phase_d   = rtr_pkg::PH_ESTABLISHED;
              exp_seq_d = seq_plus1;
              ticks_d   = '0;
            end else begin
              phase_d = rtr_pkg::PH_LISTEN;
            end
          end
          rtr_pkg::PH_ESTABLISHED: begin
            if (seg_i.seg_fin) begin
              close_seq_d = seg_i.seg_ack;
              phase_d     = rtr_pkg::PH_LAST_ACK;
            end else begin
              if (in_order) exp_seq_d = ack_val;
              if (in_order || resend) ticks_d = '0;
            end
          end
          rtr_pkg::PH_LAST_ACK: begin
            if (fin_match) phase_d = rtr_pkg::PH_CLOSED;
          end
          default: ;
        endcase
      end
    end
  end

  // queued answers
  always_comb begin
    push_o  = 1'b0;
    entry_o = '0;
    if (fire && !is_tick) begin
      case (phase_q)
        rtr_pkg::PH_LISTEN: begin
          if (seg_i.seg_syn) begin
            push_o        = 1'b1;
            entry_o.kind  = rtr_pkg::KIND_SYN_ACK;
            entry_o.seq   = isn_q;
            entry_o.ack   = seq_plus1;
          end
        end
        rtr_pkg::PH_ESTABLISHED: begin
          push_o      = 1'b1;
          entry_o.seq = seg_i.seg_ack;
          if (seg_i.seg_fin) begin
            entry_o.kind = rtr_pkg::KIND_FIN_ACK;
            entry_o.ack  = seq_plus1;
            entry_o.pair = 1'b1;
          end else begin
            entry_o.kind = rtr_pkg::KIND_ACK;
            entry_o.ack  = ack_val;
            entry_o.wlen = in_order ? seg_i.seg_length : '0;
            entry_o.pair = resend;
          end
        end
        rtr_pkg::PH_LAST_ACK: begin
          if (fin_match) begin
            push_o       = 1'b1;
            entry_o.kind = rtr_pkg::KIND_CLOSED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rtr_pkg::PH_LISTEN;
      exp_seq_q   <= '0;
      hs_ack_q    <= '0;
      close_seq_q <= '0;
      ticks_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      exp_seq_q   <= exp_seq_d;
      hs_ack_q    <= hs_ack_d;
      close_seq_q <= close_seq_d;
      ticks_q     <= ticks_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("answer queued into full queue");

  a_closed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rtr_pkg::PH_CLOSED |=> phase_q == rtr_pkg::PH_CLOSED)
    else $error("left closed phase");

endmodule

`default_nettype wire

@@ hdl/rtr_fifo.sv @@
// Answer queue between front and back end of the receiver.
// Depends on rtr_pkg for the entry type.
`default_nettype none

module rtr_fifo #(
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rtr_pkg::entry_t  entry_i,
  input  wire logic             pop_i,
  output rtr_pkg::entry_t       head_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [PtrW-1:0] PtrOne   = PtrW'(1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);

  rtr_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == DepthCnt;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
    if (push_i && !pop_i) cnt_d = cnt_q + CntOne;
    else if (!push_i && pop_i) cnt_d = cnt_q - CntOne;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt) else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ hdl/rtr_back.sv @@
// Back end: takes queued answers and sends one result word per cycle while res_o.ready,
// splitting paired answers in two. Depends on rtr_pkg and rtr_ifs.
`default_nettype none

module rtr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rtr_pkg::entry_t  head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  rtr_res_if.source             res_o
);

  rtr_pkg::entry_t res_q, res_d;
  logic            last_q, last_d;
  logic            valid_q, valid_d;
  logic            pend_q, pend_d;
  logic            load;

  assign load  = !valid_q || res_o.ready;
  assign pop_o = load && !pend_q && !empty_i;

  always_comb begin
    res_d   = res_q;
    last_d  = last_q;
    valid_d = valid_q;
    pend_d  = pend_q;
    if (load) begin
      if (pend_q) begin
        res_d.kind = (res_q.kind == rtr_pkg::KIND_FIN_ACK) ? rtr_pkg::KIND_FIN
                                                          : rtr_pkg::KIND_RESENT_ACK;
        res_d.wlen = '0;
        last_d     = 1'b1;
        pend_d     = 1'b0;
        valid_d    = 1'b1;
      end else if (!empty_i) begin
        res_d   = head_i;
        last_d  = !head_i.pair;
        pend_d  = head_i.pair;
        valid_d = 1'b1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign res_o.valid        = valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.out_seq      = res_q.seq;
  assign res_o.out_ack      = res_q.ack;
  assign res_o.out_syn      = res_q.kind == rtr_pkg::KIND_SYN_ACK;
  assign res_o.out_fin      = (res_q.kind == rtr_pkg::KIND_FIN_ACK)
                              || (res_q.kind == rtr_pkg::KIND_FIN);
  assign res_o.write_length = res_q.wlen;
  assign res_o.last         = last_q;

  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> valid_q && !last_q) else $error("second word pending without first");

endmodule

`default_nettype wire

@@ verif/rtr_answer_checker.sv @@
// Answer checker for the reliable transport receiver: follows the connection
// from accepted words and compares every answer word. Depends on rtr_pkg, rtr_ifs.
`timescale 1ns / 1ps

module rtr_answer_checker import rtr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rtr_seg_if        seg_i,
  rtr_res_if        res_i,
  rtr_cfg_if        cfg_i,
  output int        errors_o,
  output int        pending_o,
  output int        checked_o
);

  typedef struct packed {
    kind_e kind;
    seq_t  seq;
    seq_t  ack;
    logic  syn;
    logic  fin;
    len_t  wlen;
    logic  last;
  } answer_t;

  answer_t expected_answers[$];

  phase_e conn_phase;
  seq_t   next_seq;
  seq_t   hs_ack;
  seq_t   fin_seq;
  half_t  idle_ticks;
  seq_t   isn_reg;
  half_t  step_reg;
  half_t  resend_reg;

  int mismatches = 0;
  int checked    = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 30) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic compare_answer();
    answer_t want;
    want = expected_answers.pop_front();
    if (res_i.kind !== want.kind) report_mismatch("kind", 32'(res_i.kind), 32'(want.kind));
    if (res_i.out_seq !== want.seq) report_mismatch("out_seq", res_i.out_seq, want.seq);
    if (res_i.out_ack !== want.ack) report_mismatch("out_ack", res_i.out_ack, want.ack);
    if (res_i.out_syn !== want.syn) report_mismatch("out_syn", 32'(res_i.out_syn), 32'(want.syn));
    if (res_i.out_fin !== want.fin) report_mismatch("out_fin", 32'(res_i.out_fin), 32'(want.fin));
    if (res_i.write_length !== want.wlen) begin
      report_mismatch("write_length", 32'(res_i.write_length), 32'(want.wlen));
    end
    if (res_i.last !== want.last) report_mismatch("last", 32'(res_i.last), 32'(want.last));
  endtask

  task automatic predict_answers();
    logic op;
    seq_t sq;
    seq_t ak;
    logic syn;
    logic fin;
    len_t len;
    seq_t ackv;
    len_t wlen;
    op   = seg_i.opcode;
    sq   = seg_i.seg_seq;
    ak   = seg_i.seg_ack;
    syn  = seg_i.seg_syn;
    fin  = seg_i.seg_fin;
    len  = seg_i.seg_length;
    wlen = '0;
    if (op == OP_TICK) begin
      if (idle_ticks != TICK_MAX) idle_ticks++;
    end else begin
      case (conn_phase)
        PH_LISTEN: begin
          if (syn) begin
            hs_ack     = sq + 32'd1;
            conn_phase = PH_SYN_RCVD;
            expected_answers.push_back(answer_t'{KIND_SYN_ACK, isn_reg, hs_ack, 1'b1, 1'b0,
                                                 len_t'(0), 1'b1});
          end
        end
        PH_SYN_RCVD: begin
          if (!syn && sq == hs_ack && ak == isn_reg + 32'd1) begin
            conn_phase = PH_ESTABLISHED;
            next_seq   = sq + 32'd1;
            idle_ticks = '0;
          end else begin
            conn_phase = PH_LISTEN;
          end
        end
        PH_ESTABLISHED: begin
          if (fin) begin
            fin_seq    = ak;
            conn_phase = PH_LAST_ACK;
            expected_answers.push_back(answer_t'{KIND_FIN_ACK, ak, sq + 32'd1, 1'b0, 1'b1,
                                                 len_t'(0), 1'b0});
            expected_answers.push_back(answer_t'{KIND_FIN, ak, sq + 32'd1, 1'b0, 1'b1,
                                                 len_t'(0), 1'b1});
          end else begin
            if (sq == next_seq) begin
              ackv       = sq + seq_t'(step_reg);
              next_seq   = ackv;
              wlen       = len;
              idle_ticks = '0;
            end else begin
              ackv = next_seq;
            end
            if (idle_ticks >= resend_reg) begin
              idle_ticks = '0;
              expected_answers.push_back(answer_t'{KIND_ACK, ak, ackv, 1'b0, 1'b0, wlen, 1'b0});
              expected_answers.push_back(answer_t'{KIND_RESENT_ACK, ak, ackv, 1'b0, 1'b0,
                                                   len_t'(0), 1'b1});
            end else begin
              expected_answers.push_back(answer_t'{KIND_ACK, ak, ackv, 1'b0, 1'b0, wlen, 1'b1});
            end
          end
        end
        PH_LAST_ACK: begin
          if (ak == fin_seq + 32'd1) begin
            conn_phase = PH_CLOSED;
            expected_answers.push_back(answer_t'{KIND_CLOSED, seq_t'(0), seq_t'(0), 1'b0, 1'b0,
                                                 len_t'(0), 1'b1});
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_phase = PH_LISTEN;
      next_seq   = '0;
      hs_ack     = '0;
      fin_seq    = '0;
      idle_ticks = '0;
      isn_reg    = INITIAL_SEQ_RST;
      step_reg   = SEG_STEP_RST;
      resend_reg = RESEND_RST;
      expected_answers.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_INITIAL_SEQ: isn_reg    = cfg_i.data;
          CFG_SEG_STEP:    step_reg   = cfg_i.data[15:0];
          CFG_RESEND:      resend_reg = cfg_i.data[15:0];
          default: begin
          end
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected word, kind", 32'(res_i.kind), 32'hFFFF_FFFF);
        end else begin
          compare_answer();
          checked++;
        end
      end
      if (seg_i.valid && seg_i.ready) predict_answers();
    end
    errors_o  <= mismatches;
    pending_o <= expected_answers.size();
    checked_o <= checked;
  end

endmodule

@@ verif/tb_reliable_transport_receiver.sv @@
// Testbench top for the reliable transport receiver: clock, reset, segment and
// register stimulus, result back-pressure and verdict. Depends on rtr_pkg,
// rtr_ifs, the receiver RTL and rtr_answer_checker.
`timescale 1ns / 1ps

module tb_reliable_transport_receiver;
  import rtr_pkg::*;

  logic clk;
  logic rst_n;

  rtr_seg_if seg ();
  rtr_res_if res ();
  rtr_cfg_if cfg ();

  int errors;
  int pending;
  int checked;

  int    burst_left   = 0;
  bit    hold_off_req = 1'b0;
  int    words_sent   = 0;
  int    loads        = 0;
  seq_t  isn_now;
  half_t step_now;
  seq_t  next_seq_now;
  seq_t  hs_now;
  bit    syn_rcvd_now = 1'b0;

  reliable_transport_receiver i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seg_i  (seg),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  rtr_answer_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .seg_i     (seg),
    .res_i     (res),
    .cfg_i     (cfg),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic coin();
    return logic'($urandom_range(0, 1));
  endfunction

  function automatic len_t any_length();
    return len_t'($urandom_range(0, 1400));
  endfunction

  task automatic send_word(input logic op, input seq_t sq, input seq_t ak, input logic syn,
                           input logic fin, input len_t len);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        seg.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    seg.valid      <= 1'b1;
    seg.opcode     <= op;
    seg.seg_seq    <= sq;
    seg.seg_ack    <= ak;
    seg.seg_syn    <= syn;
    seg.seg_fin    <= fin;
    seg.seg_length <= len;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(OP_TICK, $urandom, $urandom, coin(), coin(), any_length());
  endtask

  task automatic put_register(input logic [1:0] index, input seq_t data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic load_settings(input seq_t isn, input half_t step, input half_t resend);
    isn_now  = isn;
    step_now = step;
    loads++;
    put_register(CFG_INITIAL_SEQ, isn);
    put_register(CFG_SEG_STEP, seq_t'(step));
    put_register(CFG_RESEND, seq_t'(resend));
    cfg.valid <= 1'b0;
  endtask

  // hold input until every answer is out, then let the pipeline drain
  task automatic settle();
    seg.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic handshake_noise(input int count);
    int   r;
    seq_t sq;
    seq_t flip;
    repeat (count) begin
      r    = $urandom_range(0, 99);
      flip = $urandom;
      if (flip == 0) flip = 32'd1;
      if (r < 15) begin
        send_tick();
      end else if (!syn_rcvd_now) begin
        sq = $urandom;
        if (r < 30) begin
          send_word(OP_SEGMENT, sq, $urandom, 1'b0, coin(), any_length());
        end else begin
          hs_now       = sq + 32'd1;
          syn_rcvd_now = 1'b1;
          send_word(OP_SEGMENT, sq, $urandom, 1'b1, coin(), any_length());
        end
      end else begin
        syn_rcvd_now = 1'b0;
        case ($urandom_range(0, 3))
          0: send_word(OP_SEGMENT, hs_now, isn_now + 32'd1, 1'b1, coin(), any_length());
          1: send_word(OP_SEGMENT, hs_now ^ flip, isn_now + 32'd1, 1'b0, coin(), any_length());
          2: send_word(OP_SEGMENT, hs_now, (isn_now + 32'd1) ^ flip, 1'b0, coin(), any_length());
          default: send_word(OP_SEGMENT, $urandom, $urandom, 1'b1, coin(), any_length());
        endcase
      end
    end
    if (syn_rcvd_now) begin
      syn_rcvd_now = 1'b0;
      send_word(OP_SEGMENT, $urandom, $urandom, 1'b1, 1'b0, len_t'(0));
    end
  endtask

  task automatic established_traffic(input int count);
    int   r;
    seq_t sq;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_tick();
      end else if (r < 75) begin
        sq           = next_seq_now;
        next_seq_now = next_seq_now + seq_t'(step_now);
        send_word(OP_SEGMENT, sq, $urandom, coin(), 1'b0, any_length());
      end else begin
        case ($urandom_range(0, 2))
          0: sq = next_seq_now - seq_t'(step_now);
          1: sq = next_seq_now + seq_t'(step_now);
          default: sq = $urandom;
        endcase
        if (sq == next_seq_now) sq = sq ^ 32'd1;
        send_word(OP_SEGMENT, sq, $urandom, coin(), 1'b0, any_length());
      end
    end
  endtask

  initial begin : result_sink
    int span;
    int mode;
    res.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int i = 0; i < span; i++) begin
        if (hold_off_req) begin
          res.ready <= 1'b0;
          repeat (300) @(posedge clk);
          hold_off_req = 1'b0;
        end
        case (mode)
          0: res.ready <= 1'b1;
          1: res.ready <= coin();
          2: res.ready <= (i % 4 == 3);
          default: res.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int   waited;
    seq_t sq;
    rst_n          <= 1'b0;
    seg.valid      <= 1'b0;
    seg.opcode     <= OP_SEGMENT;
    seg.seg_seq    <= '0;
    seg.seg_ack    <= '0;
    seg.seg_syn    <= 1'b0;
    seg.seg_fin    <= 1'b0;
    seg.seg_length <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_INITIAL_SEQ;
    cfg.data       <= '0;
    isn_now        = INITIAL_SEQ_RST;
    step_now       = SEG_STEP_RST;
    next_seq_now   = '0;
    hs_now         = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // listen and failed handshakes
    send_word(OP_TICK, '1, '1, 1'b1, 1'b1, len_t'(1400));
    send_word(OP_SEGMENT, '0, '0, 1'b0, 1'b1, len_t'(0));
    send_word(OP_SEGMENT, '1, '1, 1'b0, 1'b0, len_t'(1400));
    send_word(OP_SEGMENT, '1, '0, 1'b1, 1'b0, len_t'(0));
    send_word(OP_SEGMENT, 32'd0, 32'd1, 1'b1, 1'b0, len_t'(0));
    send_word(OP_SEGMENT, 32'd100, '1, 1'b1, 1'b1, len_t'(1400));
    send_word(OP_SEGMENT, 32'd101, 32'd2, 1'b0, 1'b0, len_t'(0));
    send_word(OP_SEGMENT, 32'd200, '0, 1'b1, 1'b0, len_t'(0));
    send_word(OP_TICK, '0, '0, 1'b0, 1'b0, len_t'(0));
    send_word(OP_SEGMENT, 32'd202, 32'd1, 1'b0, 1'b0, len_t'(0));
    settle();
    load_settings('1, SEG_STEP_RST, RESEND_RST);
    send_word(OP_SEGMENT, 32'd300, $urandom, 1'b1, 1'b0, len_t'(0));
    send_word(OP_SEGMENT, 32'd301, '1, 1'b0, 1'b0, len_t'(0));

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0: load_settings('0, half_t'(1), half_t'(0));
        1: load_settings('1, TICK_MAX, TICK_MAX);
        default: load_settings($urandom, half_t'($urandom_range(1, 65535)), half_t'($urandom));
      endcase
      handshake_noise(100);
    end

    // open the connection; the initial sequence changes between SYN and ACK
    settle();
    load_settings($urandom, SEG_STEP_RST, RESEND_RST);
    send_word(OP_SEGMENT, 32'hFFFF_FFFE, $urandom, 1'b1, 1'b0, len_t'(0));
    settle();
    load_settings(32'h7FFF_FFFF, SEG_STEP_RST, RESEND_RST);
    send_word(OP_SEGMENT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, len_t'(0));
    next_seq_now = '0;
    send_word(OP_SEGMENT, 32'd0, '0, 1'b0, 1'b0, len_t'(0));
    send_word(OP_SEGMENT, 32'd1400, '1, 1'b1, 1'b0, len_t'(1400));
    send_word(OP_SEGMENT, 32'd1400, $urandom, 1'b0, 1'b0, len_t'(700));
    send_word(OP_SEGMENT, '1, $urandom, 1'b0, 1'b0, len_t'(1));
    send_tick();
    send_tick();
    next_seq_now = 32'd2800;
    settle();
    load_settings('0, TICK_MAX, half_t'(0));
    send_word(OP_SEGMENT, next_seq_now, $urandom, 1'b0, 1'b0, len_t'(1400));
    next_seq_now = next_seq_now + seq_t'(step_now);
    send_word(OP_SEGMENT, 32'd5, $urandom, 1'b0, 1'b0, len_t'(1400));

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: load_settings($urandom, SEG_STEP_RST, RESEND_RST);
        1: load_settings('0, half_t'(1), half_t'(0));
        2: load_settings('1, TICK_MAX, half_t'(3));
        3: load_settings($urandom, half_t'($urandom_range(1, 65535)),
                         half_t'($urandom_range(1, 12)));
        4: load_settings($urandom, half_t'($urandom_range(1, 65535)), half_t'($urandom));
        default: load_settings($urandom, SEG_STEP_RST, TICK_MAX);
      endcase
      if (ph == 0) hold_off_req = 1'b1;
      established_traffic(270);
    end

    // close, with ignored words around the final ACK
    sq = $urandom;
    send_word(OP_SEGMENT, sq, '1, 1'b0, 1'b1, any_length());
    send_word(OP_SEGMENT, $urandom, 32'd5, 1'b0, 1'b0, any_length());
    send_tick();
    send_word(OP_SEGMENT, $urandom, '1, 1'b1, 1'b1, any_length());
    send_word(OP_SEGMENT, $urandom, '0, 1'b0, 1'b0, len_t'(0));
    send_word(OP_SEGMENT, $urandom, $urandom, 1'b1, 1'b0, any_length());
    send_tick();
    send_word(OP_SEGMENT, $urandom, '0, 1'b0, 1'b1, any_length());

    seg.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("run covered %0d input words over %0d register settings: handshakes, data, ticks,",
             words_sent, loads);
    $display("ack resends, back-pressure and close; %0d answer words checked", checked);
    if (errors == 0 && pending == 0) begin
      $display("PASS reliable_transport_receiver");
    end else begin
      $display("FAIL reliable_transport_receiver");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL reliable_transport_receiver");
    $finish;
  end

endmodule

@@ files.f @@
hdl/rtr_pkg.sv
hdl/rtr_ifs.sv
hdl/rtr_front.sv
hdl/rtr_fifo.sv
hdl/rtr_back.sv
hdl/reliable_transport_receiver.sv
verif/rtr_answer_checker.sv
verif/tb_reliable_transport_receiver.sv
